FILE: rtl/core/sha256_stream_hasher_core_macros.svh
// Assertion macros for the SHA-256 stream hasher core
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH

// Implication check, disabled during reset
`define SHA_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication check, disabled during reset
`define SHA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/core/sha_pkg.sv
// Package: SHA-256 constants, types and round functions
package sha_pkg;

   localparam int BufDepth  = 64;
   localparam int BufAw     = 6;
   localparam int WinDepth  = 16;
   localparam int WinAw     = 4;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOADR = 9'b000000010,
      ST_LOAD  = 9'b000000100,
      ST_ROUND = 9'b000001000,
      ST_ADD   = 9'b000010000,
      ST_PAD   = 9'b000100000,
      ST_LEN   = 9'b001000000,
      ST_EMIT  = 9'b010000000,
      ST_ZERO  = 9'b100000000
   } state_type;

   typedef logic [31:0] word_type;

   function automatic word_type initial_hash(input logic [2:0] idx);
      case (idx)
         3'd0: initial_hash = 32'h6a09e667;
         3'd1: initial_hash = 32'hbb67ae85;
         3'd2: initial_hash = 32'h3c6ef372;
         3'd3: initial_hash = 32'ha54ff53a;
         3'd4: initial_hash = 32'h510e527f;
         3'd5: initial_hash = 32'h9b05688c;
         3'd6: initial_hash = 32'h1f83d9ab;
         default: initial_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic word_type round_k(input logic [5:0] r);
      case (r)
         6'd0: round_k = 32'h428a2f98; 6'd1: round_k = 32'h71374491;
         6'd2: round_k = 32'hb5c0fbcf; 6'd3: round_k = 32'he9b5dba5;
         6'd4: round_k = 32'h3956c25b; 6'd5: round_k = 32'h59f111f1;
         6'd6: round_k = 32'h923f82a4; 6'd7: round_k = 32'hab1c5ed5;
         6'd8: round_k = 32'hd807aa98; 6'd9: round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
      endcase
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_s0(input word_type x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_s1(input word_type x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_s0(input word_type x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_s1(input word_type x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: rtl/core/sha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module sha_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/sha_round.sv
// SHA-256 round datapath: schedule word and working-variable update
module sha_round import sha_pkg::*; (
   input  word_type     vars [8],
   input  logic [5:0]   round,
   input  word_type     w_in,
   input  word_type     w2,
   input  word_type     w7,
   input  word_type     w15,
   input  word_type     w16,
   output word_type     w_out,
   output word_type     vars_out [8]
);
   word_type t1;
   word_type t2;

   always_comb begin
      w_out = (round < 6'd16) ? w_in : small_s1(w2) + w7 + small_s0(w15) + w16;
      t1 = vars[7] + big_s1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
         + round_k(round) + w_out;
      t2 = big_s0(vars[0]) + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
      vars_out[7] = vars[6];
      vars_out[6] = vars[5];
      vars_out[5] = vars[4];
      vars_out[4] = vars[3] + t1;
      vars_out[3] = vars[2];
      vars_out[2] = vars[1];
      vars_out[1] = vars[0];
      vars_out[0] = t1 + t2;
   end
endmodule

FILE: rtl/core/sha256_stream_hasher_core.sv
// Top level: SHA-256 byte stream hasher with block buffer in RAM
//
// channel  dir  ports                                        meaning
// req      in   req_valid req_ready req_operation req_data_byte  absorb byte / finish
// rsp      out  rsp_valid rsp_ready rsp_digest_word rsp_word_index rsp_last_word
//
// An absorb writes one byte to the buffer; the 64th byte of a block adds a compression:
// one read setup, 64 buffer reads build the schedule (one RAM read port), 64 rounds,
// one hash add.
// Finish pads the buffer one byte a cycle, compresses once or twice, then emits eight items.
// A synchronous reset returns the hash words, count and length to their initial values.
// A stalled rsp_ready holds the current digest item; req_ready is low until done.
`include "sha256_stream_hasher_core_macros.svh"
module sha256_stream_hasher_core import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   state_type state_ff, state_in;
   logic [BufAw-1:0] fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   word_type hash_ff [8];
   word_type hash_in [8];
   word_type vars_ff [8];
   word_type vars_in [8];
   word_type vars_nx [8];
   logic [6:0] cnt_ff, cnt_in;
   logic [5:0] rnd_ff, rnd_in;
   word_type   wacc_ff, wacc_in;
   logic       final_ff, final_in;
   logic       second_ff, second_in;
   logic [2:0] widx_ff, widx_in;

   logic             buf_we;
   logic [BufAw-1:0] buf_wa, buf_ra;
   logic [7:0]       buf_wd, buf_rd;
   logic             win_we;
   logic [WinAw-1:0] win_wa;
   word_type         win_wd, w2, w7, w15, w16, w_new;
   logic [WinAw-1:0] r4;
   logic [63:0]      total;

   sha_ram #(.Width(8), .Depth(BufDepth)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(buf_wd),
      .rd_addr(buf_ra), .rd_data(buf_rd)
   );

   // schedule window is a 16-entry register file read at fixed offsets of the round
   word_type win_ff [WinDepth];

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_ff[win_wa] <= win_wd;
      end
   end

   assign r4  = rnd_ff[WinAw-1:0];
   assign w2  = win_ff[r4 - 4'd2];
   assign w7  = win_ff[r4 - 4'd7];
   assign w15 = win_ff[r4 - 4'd15];
   assign w16 = win_ff[r4];

   sha_round u_round (
      .vars(vars_ff), .round(rnd_ff), .w_in(win_ff[r4]), .w2(w2), .w7(w7),
      .w15(w15), .w16(w16), .w_out(w_new), .vars_out(vars_nx)
   );

   assign total = bits_ff + {55'd0, fill_ff, 3'd0};
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_digest_word = hash_ff[widx_ff];
   assign rsp_word_index = widx_ff;
   assign rsp_last_word = (widx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      hash_in = hash_ff;
      vars_in = vars_ff;
      cnt_in = cnt_ff;
      rnd_in = rnd_ff;
      wacc_in = wacc_ff;
      final_in = final_ff;
      second_in = second_ff;
      widx_in = widx_ff;
      buf_we = 1'b0;
      buf_wa = fill_ff;
      buf_wd = req_data_byte;
      buf_ra = cnt_ff[BufAw-1:0];
      win_we = 1'b0;
      win_wa = cnt_ff[5:2];
      win_wd = {wacc_ff[23:0], buf_rd};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_ABSORB) begin
                  buf_we = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     final_in = 1'b0;
                     cnt_in = 7'd0;
                     state_in = ST_LOADR;
                  end
               end else begin
                  buf_we = 1'b1;
                  buf_wd = 8'h80;
                  cnt_in = {1'b0, fill_ff} + 7'd1;
                  second_in = (fill_ff >= 6'd56);
                  final_in = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (cnt_ff == 7'd64) begin
               cnt_in = 7'd0;
               if (second_ff) begin
                  state_in = ST_LOADR;
               end else begin
                  state_in = ST_LEN;
               end
            end else begin
               buf_we = 1'b1;
               buf_wa = cnt_ff[BufAw-1:0];
               buf_wd = 8'h00;
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_ZERO: begin
            buf_we = 1'b1;
            buf_wa = cnt_ff[BufAw-1:0];
            buf_wd = 8'h00;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd55) begin
               cnt_in = 7'd0;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            buf_we = 1'b1;
            buf_wa = 6'd56 + cnt_ff[5:0];
            buf_wd = total[6'(63 - 8 * cnt_ff[2:0]) -: 8];
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd7) begin
               cnt_in = 7'd0;
               second_in = 1'b0;
               state_in = ST_LOADR;
            end
         end
         ST_LOADR: begin
            cnt_in = 7'd1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            buf_ra = cnt_ff[BufAw-1:0];
            wacc_in = {wacc_ff[23:0], buf_rd};
            win_wa = 4'(((cnt_ff - 7'd1) >> 2));
            win_we = ((cnt_ff - 7'd1) & 7'd3) == 7'd3;
            if (cnt_ff != 7'd64) begin
               cnt_in = cnt_ff + 7'd1;
            end else begin
               vars_in = hash_ff;
               rnd_in = 6'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            vars_in = vars_nx;
            win_we = 1'b1;
            win_wa = r4;
            win_wd = w_new;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            cnt_in = 7'd0;
            if (!final_ff) begin
               bits_in = bits_ff + 64'd512;
               state_in = ST_IDLE;
            end else if (second_ff) begin
               state_in = ST_ZERO;
            end else begin
               widx_in = 3'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     hash_in[i] = initial_hash(3'(i));
                  end
                  fill_in = '0;
                  bits_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         bits_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= initial_hash(3'(i));
         end
         cnt_ff <= '0;
         final_ff <= 1'b0;
         second_ff <= 1'b0;
         widx_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         hash_ff <= hash_in;
         cnt_ff <= cnt_in;
         final_ff <= final_in;
         second_ff <= second_in;
         widx_ff <= widx_in;
      end
      vars_ff <= vars_in;
      rnd_ff <= rnd_in;
      wacc_ff <= wacc_in;
   end

   `SHA_ASSERT_IMP(a_onehot_state, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `SHA_ASSERT_IMP(a_ready_excl, clock, reset, rsp_valid, !req_ready, "req and rsp both open")
   `SHA_ASSERT_NEXT(a_last_done, clock, reset, rsp_valid && rsp_ready && rsp_last_word,
      req_ready && fill_ff == 6'd0, "no restart after last word")
   `SHA_ASSERT_NEXT(a_round_wrap, clock, reset, state_ff == ST_ROUND && rnd_ff == 6'd63,
      state_ff == ST_ADD, "round count overrun")
endmodule

FILE: dv/sha256_stream_hasher_core_tb.sv
// Testbench for the SHA-256 byte stream hasher core: directed and random messages
`timescale 1ns / 100ps
module sha256_stream_hasher_core_tb;
   import sha_pkg::*;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_ABSORB;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_item_type digest_queue[$];
   int          mismatch_count = 0;
   bit          hold_rsp = 1'b0;

   logic [7:0]  pend_bytes[64];
   logic [5:0]  pend_count;
   logic [63:0] hashed_bits;
   logic [31:0] chain[8];

   localparam logic [31:0] K_TAB[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] IV_TAB[8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
      32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   sha256_stream_hasher_core DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_hash();
      pend_count = '0;
      hashed_bits = '0;
      for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
   endtask

   task automatic compress_pending();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {pend_bytes[4*i], pend_bytes[4*i+1], pend_bytes[4*i+2], pend_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic predict_digest(logic op, logic [7:0] b);
      int p;
      logic [63:0] total;
      digest_item_type e;
      if (op == OP_ABSORB) begin
         pend_bytes[pend_count] = b;
         pend_count++;
         if (pend_count == 0) begin
            compress_pending();
            hashed_bits += 64'd512;
         end
         return;
      end
      p = pend_count;
      pend_bytes[p] = 8'h80;
      for (int i = p + 1; i < 64; i++) pend_bytes[i] = 8'h00;
      if (p >= 56) begin
         compress_pending();
         for (int i = 0; i < 64; i++) pend_bytes[i] = 8'h00;
      end
      total = hashed_bits + 64'(p) * 8;
      for (int i = 0; i < 8; i++) pend_bytes[63-i] = total[8*i +: 8];
      compress_pending();
      for (int i = 0; i < 8; i++) begin
         e.digest_word = chain[i];
         e.word_index = 3'(i);
         e.last_word = (i == 7);
         digest_queue.push_back(e);
      end
      restart_hash();
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   task automatic send_item(logic op, logic [7:0] b, bit idle = 1'b1);
      int g;
      g = idle ? gap_len() : 0;
      if ($urandom_range(0, 2) == 0) g = 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_digest(op, b);
   endtask

   task automatic send_message(int n, int fill);
      for (int i = 0; i < n; i++)
         send_item(OP_ABSORB, (fill < 0) ? 8'($urandom) : 8'(fill));
      send_item(OP_FINISH, 8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_empty_and_extremes();
      send_item(OP_FINISH, 8'hff);
      send_message(1, 8'h00);
      send_message(1, 8'hff);
      send_message(3, -1);
      drain();
   endtask

   task automatic test_padding_boundaries();
      send_message(55, -1);
      send_message(56, -1);
      send_message(63, -1);
      send_message(64, -1);
      send_message(65, -1);
      drain();
   endtask

   task automatic test_back_to_back_stall();
      hold_rsp = 1'b1;
      send_message(5, -1);
      send_item(OP_ABSORB, 8'h5a, 1'b0);
      send_item(OP_FINISH, 8'h00, 1'b0);
      drain();
   endtask

   task automatic test_random_messages();
      int n, r, len;
      n = 0;
      while (n < 126) begin
         r = $urandom_range(0, 9);
         if (r < 6) len = $urandom_range(0, 8);
         else if (r < 9) len = $urandom_range(50, 70);
         else len = $urandom_range(120, 135);
         send_message(len, -1);
         n += len + 1;
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 9) < 6);
      end
   end

   initial begin
      int held;
      wait (hold_rsp);
      held = 0;
      while (held < 300) begin
         @(posedge clock);
         held++;
      end
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      digest_item_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected digest item %h", rsp_digest_word);
         end else begin
            e = digest_queue.pop_front();
            if (e.digest_word !== rsp_digest_word || e.word_index !== rsp_word_index ||
                e.last_word !== rsp_last_word) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp %h/%0d/%b got %h/%0d/%b", e.digest_word,
                     e.word_index, e.last_word, rsp_digest_word, rsp_word_index,
                     rsp_last_word);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      restart_hash();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_extremes();
      test_padding_boundaries();
      test_back_to_back_stall();
      test_random_messages();
      if (mismatch_count == 0 && digest_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

FILE: sha256_stream_hasher_core.f
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_ram.sv
rtl/core/sha_round.sv
rtl/core/sha256_stream_hasher_core.sv
dv/sha256_stream_hasher_core_tb.sv
